>>> hw/rtl/almd_pkg.sv
// shared types and constants for the integer alu pipeline
// no dependencies
package almd_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned OpWidth = 4;
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned DivStages = DataWidth / StepsPerStage;

  localparam logic [OpWidth-1:0] OpAnd  = 4'd0;
  localparam logic [OpWidth-1:0] OpOr   = 4'd1;
  localparam logic [OpWidth-1:0] OpAdd  = 4'd2;
  localparam logic [OpWidth-1:0] OpXor  = 4'd3;
  localparam logic [OpWidth-1:0] OpSltu = 4'd4;
  localparam logic [OpWidth-1:0] OpNor  = 4'd5;
  localparam logic [OpWidth-1:0] OpSub  = 4'd6;
  localparam logic [OpWidth-1:0] OpSlt  = 4'd7;
  localparam logic [OpWidth-1:0] OpMul  = 4'd8;
  localparam logic [OpWidth-1:0] OpDiv  = 4'd9;

  typedef struct packed {
    logic                 valid;
    logic                 is_div;
    logic                 neg;
    logic                 dz;
    logic [DataWidth-1:0] res;
    logic [DataWidth-1:0] rem;
    logic [DataWidth-1:0] quo;
    logic [DataWidth-1:0] dsr;
  } stage_t;

endpackage

>>> hw/rtl/almd_if.sv
// valid/ready channels for alu operation words and result words
// depends on almd_pkg
interface almd_req_if;
  logic                              valid;
  logic                              ready;
  logic [almd_pkg::OpWidth-1:0]      op;
  logic signed [almd_pkg::DataWidth-1:0] operand_a;
  logic signed [almd_pkg::DataWidth-1:0] operand_b;
  modport source (output valid, op, operand_a, operand_b, input ready);
  modport sink (input valid, op, operand_a, operand_b, output ready);
endinterface

interface almd_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [almd_pkg::DataWidth-1:0] result;
  logic                                  div_by_zero;
  modport source (output valid, result, div_by_zero, input ready);
  modport sink (input valid, result, div_by_zero, output ready);
endinterface

>>> hw/rtl/almd_front.sv
// first stage: logic, add, compare, multiply and divider setup
// depends on almd_pkg
module almd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           valid_in,
  input  logic [almd_pkg::OpWidth-1:0]   op,
  input  logic [almd_pkg::DataWidth-1:0] a,
  input  logic [almd_pkg::DataWidth-1:0] b,
  output almd_pkg::stage_t               stage
);
  import almd_pkg::*;

  stage_t stage_next;
  logic [DataWidth-1:0] mag_a;
  logic [DataWidth-1:0] mag_b;
  logic [DataWidth-1:0] sum;
  logic [DataWidth-1:0] diff;
  logic [DataWidth-1:0] prod;

  always_comb begin
    mag_a = a[DataWidth-1] ? (~a + 1'b1) : a;
    mag_b = b[DataWidth-1] ? (~b + 1'b1) : b;
    sum   = a + b;
    diff  = a - b;
    prod  = a * b;
    stage_next        = '0;
    stage_next.valid  = valid_in;
    stage_next.neg    = a[DataWidth-1] ^ b[DataWidth-1];
    stage_next.quo    = mag_a;
    stage_next.dsr    = mag_b;
    case (op)
      OpAnd:  stage_next.res = a & b;
      OpOr:   stage_next.res = a | b;
      OpAdd:  stage_next.res = sum;
      OpXor:  stage_next.res = a ^ b;
      OpSltu: stage_next.res = {{(DataWidth-1){1'b0}}, a < b};
      OpNor:  stage_next.res = ~(a | b);
      OpSub:  stage_next.res = diff;
      OpSlt:  stage_next.res = {{(DataWidth-1){1'b0}}, $signed(a) < $signed(b)};
      OpMul:  stage_next.res = prod;
      OpDiv: begin
        if (b == '0) begin
          stage_next.dz = 1'b1;
        end else begin
          stage_next.is_div = 1'b1;
        end
      end
      default: stage_next.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage.valid <= stage_next.valid;
    end
    if (en) begin
      stage.is_div <= stage_next.is_div;
      stage.neg    <= stage_next.neg;
      stage.dz     <= stage_next.dz;
      stage.res    <= stage_next.res;
      stage.rem    <= stage_next.rem;
      stage.quo    <= stage_next.quo;
      stage.dsr    <= stage_next.dsr;
    end
  end

endmodule

>>> hw/rtl/almd_div_step.sv
// one divider stage: four restoring quotient bits per stage, registered when en is high
// depends on almd_pkg
module almd_div_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  almd_pkg::stage_t stage_in,
  output almd_pkg::stage_t stage
);
  import almd_pkg::*;

  stage_t stage_next;
  logic [DataWidth:0]   trial;
  logic [DataWidth-1:0] rem;
  logic [DataWidth-1:0] quo;

  always_comb begin
    rem = stage_in.rem;
    quo = stage_in.quo;
    trial = '0;
    for (int i = 0; i < StepsPerStage; i++) begin
      trial = {rem, quo[DataWidth-1]};
      quo = {quo[DataWidth-2:0], 1'b0};
      if (trial >= {1'b0, stage_in.dsr}) begin
        trial = trial - {1'b0, stage_in.dsr};
        quo[0] = 1'b1;
      end
      rem = trial[DataWidth-1:0];
    end
    stage_next     = stage_in;
    stage_next.rem = rem;
    stage_next.quo = quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage.valid <= stage_next.valid;
    end
    if (en) begin
      stage.is_div <= stage_next.is_div;
      stage.neg    <= stage_next.neg;
      stage.dz     <= stage_next.dz;
      stage.res    <= stage_next.res;
      stage.rem    <= stage_next.rem;
      stage.quo    <= stage_next.quo;
      stage.dsr    <= stage_next.dsr;
    end
  end

endmodule

>>> hw/rtl/alu_logic_arith_mul_div.sv
// top level of the pipelined 32-bit integer alu
// depends on almd_pkg, almd_if, almd_front, almd_div_step
//
// usage:
//   req carries an operation word (op, operand_a, operand_b); rsp returns
//   one result word (result, div_by_zero) for every operation word, in order.
//   every op takes the same path: one setup stage (logic, add, compare,
//   32x32 multiply), eight divider stages of four quotient bits each, and an
//   output stage that applies the quotient sign.
//   throughput is one word per cycle for all ops, divide included, unless rsp stalls.
//   the whole pipeline advances together; when rsp is stalled with a word
//   waiting, req.ready drops and every stage holds its word.
//   empty stages do not hold up the pipe while the output is free.
//   reset clears all valid bits; req.ready is high right after reset.
//   divide by zero gives result 0 with div_by_zero set; unknown ops give 0.
module alu_logic_arith_mul_div (
  input logic       clk,
  input logic       rst,
  almd_req_if.sink  req,
  almd_rsp_if.source rsp
);
  import almd_pkg::*;

  logic   en;
  stage_t pipe [DivStages+1];
  logic [DataWidth-1:0] quo_signed;
  logic [DataWidth-1:0] result_next;

  assign en = !rsp.valid || rsp.ready;
  assign req.ready = en;

  almd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (req.valid),
    .op       (req.op),
    .a        (req.operand_a),
    .b        (req.operand_b),
    .stage    (pipe[0])
  );

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    almd_div_step u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .stage_in (pipe[s]),
      .stage    (pipe[s+1])
    );
  end

  always_comb begin
    quo_signed  = pipe[DivStages].neg ? (~pipe[DivStages].quo + 1'b1)
                                      : pipe[DivStages].quo;
    result_next = pipe[DivStages].is_div ? quo_signed : pipe[DivStages].res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= pipe[DivStages].valid;
    end
    if (en) begin
      rsp.result      <= result_next;
      rsp.div_by_zero <= pipe[DivStages].dz;
    end
  end

endmodule
